// File: sv/ecrm_pkg.sv
// ecrm_pkg: shared types and constants for the equity curve risk metrics block
// used by ecrm_div, ecrm_sqrt and equity_curve_risk_metrics; depends on nothing
`timescale 1ns / 1ps

package ecrm_pkg;

   localparam int DVD_W   = 96;
   localparam int DEN_W   = 64;
   localparam int QUO_W   = 64;
   localparam int STEP_W  = 7;
   localparam int RAD_W   = 64;
   localparam int ROOT_W  = 40;
   localparam int SQRT_STEPS = 40;
   localparam int SQUARE_DROP = 16;
   localparam int RATIO_FRAC  = 16;
   localparam int DD_FRAC     = 32;

   localparam logic CSR_INITIAL_EQUITY = 1'b0;
   localparam logic CSR_RISK_FREE      = 1'b1;

   localparam logic [QUO_W-1:0] CAP_NONE    = '1;
   localparam logic [QUO_W-1:0] CAP_POS     = 64'h0000_0000_7FFF_FFFF;
   localparam logic [QUO_W-1:0] CAP_NEG     = 64'h0000_0000_8000_0000;
   localparam logic [QUO_W-1:0] CAP_DD      = 64'h0000_0001_0000_0000;

   typedef struct packed {
      logic              start;
      logic [DVD_W-1:0]  dvd;
      logic [STEP_W-1:0] steps;
      logic [DEN_W-1:0]  den;
      logic [QUO_W-1:0]  cap;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quo;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [RAD_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

// File: sv/ecrm_div.sv
// ecrm_div: restoring divider, one quotient bit per cycle, result capped
// depends on ecrm_pkg
`timescale 1ns / 1ps

module ecrm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  ecrm_pkg::div_req_type div_req,
   output ecrm_pkg::div_rsp_type div_rsp
);
   import ecrm_pkg::*;

   logic [DVD_W-1:0]  dvd_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [QUO_W-1:0]  cap_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic              ovf_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [DEN_W:0]    rem_sh;
   logic              ge;
   logic [DEN_W:0]    rem_sub;

   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (div_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= div_req.steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dvd;
         den_ff <= div_req.den;
         cap_ff <= div_req.cap;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], ge};
         ovf_ff <= ovf_ff | quo_ff[QUO_W-1];
      end
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = (ovf_ff || quo_ff > cap_ff) ? cap_ff : quo_ff;

endmodule

// File: sv/ecrm_sqrt.sv
// ecrm_sqrt: bitwise integer square root of value * 2^16, one root bit per cycle
// depends on ecrm_pkg
`timescale 1ns / 1ps

module ecrm_sqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  ecrm_pkg::sqrt_req_type sqrt_req,
   output ecrm_pkg::sqrt_rsp_type sqrt_rsp
);
   import ecrm_pkg::*;

   localparam int OP_W  = 2 * SQRT_STEPS;
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(SQRT_STEPS + 1);

   logic [OP_W-1:0]   op_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [REM_W+1:0]  rem_sh;
   logic [REM_W+1:0]  trial;
   logic              ge;
   logic [REM_W+1:0]  rem_sub;

   assign rem_sh  = {rem_ff, op_ff[OP_W-1 -: 2]};
   assign trial   = {2'b00, root_ff, 2'b01};
   assign ge      = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (sqrt_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(SQRT_STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sqrt_req.start) begin
         op_ff   <= {sqrt_req.value, {(OP_W-RAD_W){1'b0}}};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         op_ff   <= op_ff << 2;
         rem_ff  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign sqrt_rsp.busy = busy_ff;
   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = root_ff;

endmodule

// File: sv/equity_curve_risk_metrics.sv
// equity_curve_risk_metrics: top level, sample sequencer, running statistics and
// result register; uses ecrm_pkg, ecrm_div and ecrm_sqrt
`timescale 1ns / 1ps
//
// Usage
//   req_* carries one equity sample per word; req_last marks the final sample of
//   a curve. req_stall is high while a sample is being worked on.
//   rsp_* carries one result word per curve, produced by the sample marked last.
//   csr_* writes initial_equity (index 0) and risk_free_annual (index 1); write
//   only while the block is idle.
// Work per sample
//   A sample takes up to one bit-serial division for the return and one for the
//   drawdown, both through the single shared divider, plus the square and the
//   accumulations. A sample marked last adds up to seven more divisions (64
//   steps or fewer each) and two 40-step square roots. The shared divider sets
//   the rate.
// Reset and stall
//   Reset clears all curve state, sets initial_equity to 1 and the risk-free
//   rate to 0. After a result the curve state clears for the next curve.
//   A finished result waits in the output register while rsp_stall is high;
//   new samples are still taken, and only the next result waits for it.

module equity_curve_risk_metrics #(
   parameter int COUNT_BITS       = 24,
   parameter int RETURN_FRAC_BITS = 30,
   parameter int EQUITY_BITS      = 47
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [EQUITY_BITS-1:0]                 req_equity,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [31:0]                            rsp_volatility,
   output logic signed [31:0]                     rsp_sharpe_tick,
   output logic signed [31:0]                     rsp_sortino_tick,
   output logic [32:0]                            rsp_max_drawdown,
   output logic [COUNT_BITS-1:0]                  rsp_drawdown_length,
   output logic [EQUITY_BITS-1:0]                 rsp_peak_equity,
   output logic signed [31:0]                     rsp_total_return,
   output logic [COUNT_BITS-1:0]                  rsp_return_count,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [((EQUITY_BITS > 16) ? EQUITY_BITS : 16)-1:0] csr_data
);
   import ecrm_pkg::*;

   localparam int EB     = EQUITY_BITS;
   localparam int CB     = COUNT_BITS;
   localparam int RF     = RETURN_FRAC_BITS;
   localparam int SUM_W  = CB + RF + 2;
   localparam int MEAN_W = RF + 2;
   localparam int NUM_W  = RF + 3;
   localparam int SQ_W   = 64 - SQUARE_DROP;
   localparam logic [CB-1:0]    CNT_MAX = '1;
   localparam logic [QUO_W-1:0] RET_CAP = QUO_W'(1) << (RF + 1);

   typedef enum logic [28:0] {
      ST_IDLE      = 29'(1 << 0),
      ST_RET_GO    = 29'(1 << 1),
      ST_RET_WAIT  = 29'(1 << 2),
      ST_SQ_MUL    = 29'(1 << 3),
      ST_SQ_ACC    = 29'(1 << 4),
      ST_DD_GO     = 29'(1 << 5),
      ST_DD_WAIT   = 29'(1 << 6),
      ST_MEAN_GO   = 29'(1 << 7),
      ST_MEAN_WAIT = 29'(1 << 8),
      ST_MSQ_MUL   = 29'(1 << 9),
      ST_MSQ_LATCH = 29'(1 << 10),
      ST_NM_LO     = 29'(1 << 11),
      ST_NM_HI     = 29'(1 << 12),
      ST_DEV       = 29'(1 << 13),
      ST_VAR_GO    = 29'(1 << 14),
      ST_VAR_WAIT  = 29'(1 << 15),
      ST_SD_WAIT   = 29'(1 << 16),
      ST_RF_GO     = 29'(1 << 17),
      ST_RF_WAIT   = 29'(1 << 18),
      ST_SH_GO     = 29'(1 << 19),
      ST_SH_WAIT   = 29'(1 << 20),
      ST_DOWN_GO   = 29'(1 << 21),
      ST_DVAR_WAIT = 29'(1 << 22),
      ST_DSD_WAIT  = 29'(1 << 23),
      ST_SO_GO     = 29'(1 << 24),
      ST_SO_WAIT   = 29'(1 << 25),
      ST_TR_GO     = 29'(1 << 26),
      ST_TR_WAIT   = 29'(1 << 27),
      ST_OUT       = 29'(1 << 28)
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [EB-1:0]     init_ff;
   logic [15:0]       rfa_ff;

   // curve state
   logic [EB-1:0]     prev_ff;
   logic [CB-1:0]     sidx_ff;
   logic [CB-1:0]     rs_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [63:0]       sqsum_ff;
   logic [63:0]       dsq_ff;
   logic [CB-1:0]     dcnt_ff;
   logic [EB-1:0]     dpk_ff;
   logic [EB-1:0]     opk_ff;
   logic [32:0]       worst_ff;
   logic [CB-1:0]     pos_ff;
   logic [CB-1:0]     ws_ff;
   logic [CB-1:0]     we_ff;

   // current word
   logic [EB-1:0]     e_ff;
   logic              last_ff;
   logic [CB-1:0]     idx_ff;

   // work registers
   logic [MEAN_W-1:0] mag_ff;
   logic              mag_neg_ff;
   logic [63:0]       prod_ff;
   logic [63:0]       plo_ff;
   logic [SQ_W-1:0]   msq_ff;
   logic [63:0]       dev_ff;
   logic [MEAN_W-1:0] mean_ff;
   logic              mean_neg_ff;
   logic [ROOT_W-1:0] sd_ff;
   logic [ROOT_W-1:0] dsd_ff;
   logic [NUM_W-1:0]  num_ff;
   logic              sh_neg_ff;
   logic [31:0]       sharpe_ff;
   logic [31:0]       sortino_ff;
   logic [31:0]       tr_ff;

   // result register
   logic              rsp_valid_ff;
   logic [31:0]       o_vol_ff;
   logic [31:0]       o_sharpe_ff;
   logic [31:0]       o_sortino_ff;
   logic [32:0]       o_dd_ff;
   logic [CB-1:0]     o_len_ff;
   logic [EB-1:0]     o_peak_ff;
   logic [31:0]       o_tr_ff;
   logic [CB-1:0]     o_cnt_ff;

   div_req_type  div_req;
   div_rsp_type  div_rsp;
   sqrt_req_type sqrt_req;
   sqrt_rsp_type sqrt_rsp;

   logic        in_take;
   logic        out_take;
   logic        out_load;
   logic        ret_ok;
   logic        ret_neg;
   logic [EB-1:0] ret_diff;
   logic        sum_neg;
   logic [SUM_W-1:0] sum_abs;
   logic        tr_neg;
   logic [EB-1:0] tr_diff;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [SQ_W-1:0] sq;
   logic [64:0] sqsum_add;
   logic [64:0] dsq_add;
   logic [79:0] nm_full;
   logic [63:0] nm;
   logic [63:0] n_times_252;
   logic [RF-1:0] rf_q;
   logic [NUM_W-1:0] rf_ext;
   logic [NUM_W-1:0] mean_ext;

   ecrm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ecrm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign in_take   = req_valid && !req_stall;
   assign out_take  = rsp_valid_ff && !rsp_stall;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   assign ret_ok   = (prev_ff != '0) && (rs_ff != CNT_MAX);
   assign ret_neg  = e_ff < prev_ff;
   assign ret_diff = ret_neg ? (prev_ff - e_ff) : (e_ff - prev_ff);
   assign sum_neg  = sum_ff[SUM_W-1];
   assign sum_abs  = sum_neg ? (~sum_ff + 1'b1) : sum_ff;
   assign tr_neg   = e_ff < init_ff;
   assign tr_diff  = tr_neg ? (init_ff - e_ff) : (e_ff - init_ff);

   assign sq        = prod_ff[63:SQUARE_DROP];
   assign sqsum_add = {1'b0, sqsum_ff} + 65'(sq);
   assign dsq_add   = {1'b0, dsq_ff} + 65'(sq);
   assign nm_full   = 80'(plo_ff) + (80'(prod_ff) << 32);
   assign nm        = (|nm_full[79:64]) ? '1 : nm_full[63:0];
   assign n_times_252 = (64'(rs_ff) << 8) - (64'(rs_ff) << 2);
   assign rf_q      = div_rsp.quo[RF-1:0];
   assign rf_ext    = NUM_W'(rf_q);
   assign mean_ext  = NUM_W'(mean_ff);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ_MUL: begin
            mul_a = 32'(mag_ff);
            mul_b = 32'(mag_ff);
         end
         ST_MSQ_MUL: begin
            mul_a = 32'(mean_ff);
            mul_b = 32'(mean_ff);
         end
         ST_NM_LO: begin
            mul_a = msq_ff[31:0];
            mul_b = 32'(rs_ff);
         end
         ST_NM_HI: begin
            mul_a = 32'(msq_ff[SQ_W-1:32]);
            mul_b = 32'(rs_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // divider and root requests
   always_comb begin
      div_req  = '0;
      sqrt_req = '0;
      unique case (state_ff)
         ST_RET_GO: begin
            div_req.start = ret_ok;
            div_req.dvd   = {ret_diff, {(DVD_W-EB){1'b0}}};
            div_req.steps = STEP_W'(EB + RF);
            div_req.den   = DEN_W'(prev_ff);
            div_req.cap   = RET_CAP;
         end
         ST_DD_GO: begin
            div_req.start = (dpk_ff != '0);
            div_req.dvd   = {dpk_ff - e_ff, {(DVD_W-EB){1'b0}}};
            div_req.steps = STEP_W'(EB + DD_FRAC);
            div_req.den   = DEN_W'(dpk_ff);
            div_req.cap   = CAP_DD;
         end
         ST_MEAN_GO: begin
            div_req.start = (rs_ff != '0);
            div_req.dvd   = {sum_abs, {(DVD_W-SUM_W){1'b0}}};
            div_req.steps = STEP_W'(SUM_W);
            div_req.den   = DEN_W'(rs_ff);
            div_req.cap   = CAP_NONE;
         end
         ST_VAR_GO: begin
            div_req.start = 1'b1;
            div_req.dvd   = {dev_ff, {(DVD_W-64){1'b0}}};
            div_req.steps = STEP_W'(64);
            div_req.den   = DEN_W'(rs_ff - 1'b1);
            div_req.cap   = CAP_NONE;
         end
         ST_VAR_WAIT: begin
            sqrt_req.start = div_rsp.done;
            sqrt_req.value = div_rsp.quo;
         end
         ST_RF_GO: begin
            div_req.start = 1'b1;
            div_req.dvd   = {rfa_ff, {(DVD_W-16){1'b0}}};
            div_req.steps = STEP_W'(RF);
            div_req.den   = n_times_252;
            div_req.cap   = CAP_NONE;
         end
         ST_SH_GO: begin
            div_req.start = 1'b1;
            div_req.dvd   = {num_ff, {(DVD_W-NUM_W){1'b0}}};
            div_req.steps = STEP_W'(NUM_W + RATIO_FRAC);
            div_req.den   = DEN_W'(sd_ff);
            div_req.cap   = sh_neg_ff ? CAP_NEG : CAP_POS;
         end
         ST_DOWN_GO: begin
            div_req.start = (dcnt_ff != '0);
            div_req.dvd   = {dsq_ff, {(DVD_W-64){1'b0}}};
            div_req.steps = STEP_W'(64);
            div_req.den   = DEN_W'(dcnt_ff);
            div_req.cap   = CAP_NONE;
         end
         ST_DVAR_WAIT: begin
            sqrt_req.start = div_rsp.done;
            sqrt_req.value = div_rsp.quo;
         end
         ST_SO_GO: begin
            div_req.start = 1'b1;
            div_req.dvd   = {mean_ff, {(DVD_W-MEAN_W){1'b0}}};
            div_req.steps = STEP_W'(MEAN_W + RATIO_FRAC);
            div_req.den   = DEN_W'(dsd_ff);
            div_req.cap   = mean_neg_ff ? CAP_NEG : CAP_POS;
         end
         ST_TR_GO: begin
            div_req.start = (init_ff != '0);
            div_req.dvd   = {tr_diff, {(DVD_W-EB){1'b0}}};
            div_req.steps = STEP_W'(EB + RATIO_FRAC);
            div_req.den   = DEN_W'(init_ff);
            div_req.cap   = tr_neg ? CAP_NEG : CAP_POS;
         end
         default: begin
            div_req  = '0;
            sqrt_req = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (in_take) state_in = ST_RET_GO;
         ST_RET_GO:    state_in = ret_ok ? ST_RET_WAIT : ST_DD_GO;
         ST_RET_WAIT:  if (div_rsp.done) state_in = ST_SQ_MUL;
         ST_SQ_MUL:    state_in = ST_SQ_ACC;
         ST_SQ_ACC:    state_in = ST_DD_GO;
         ST_DD_GO: begin
            if (dpk_ff != '0) state_in = ST_DD_WAIT;
            else state_in = last_ff ? ST_MEAN_GO : ST_IDLE;
         end
         ST_DD_WAIT: begin
            if (div_rsp.done) state_in = last_ff ? ST_MEAN_GO : ST_IDLE;
         end
         ST_MEAN_GO:   state_in = (rs_ff != '0) ? ST_MEAN_WAIT : ST_DOWN_GO;
         ST_MEAN_WAIT: begin
            if (div_rsp.done) state_in = (rs_ff > CB'(1)) ? ST_MSQ_MUL : ST_DOWN_GO;
         end
         ST_MSQ_MUL:   state_in = ST_MSQ_LATCH;
         ST_MSQ_LATCH: state_in = ST_NM_LO;
         ST_NM_LO:     state_in = ST_NM_HI;
         ST_NM_HI:     state_in = ST_DEV;
         ST_DEV:       state_in = ST_VAR_GO;
         ST_VAR_GO:    state_in = ST_VAR_WAIT;
         ST_VAR_WAIT:  if (div_rsp.done) state_in = ST_SD_WAIT;
         ST_SD_WAIT: begin
            if (sqrt_rsp.done) state_in = (sqrt_rsp.root != '0) ? ST_RF_GO : ST_DOWN_GO;
         end
         ST_RF_GO:     state_in = ST_RF_WAIT;
         ST_RF_WAIT:   if (div_rsp.done) state_in = ST_SH_GO;
         ST_SH_GO:     state_in = ST_SH_WAIT;
         ST_SH_WAIT:   if (div_rsp.done) state_in = ST_DOWN_GO;
         ST_DOWN_GO:   state_in = (dcnt_ff != '0) ? ST_DVAR_WAIT : ST_TR_GO;
         ST_DVAR_WAIT: if (div_rsp.done) state_in = ST_DSD_WAIT;
         ST_DSD_WAIT: begin
            if (sqrt_rsp.done) state_in = (sqrt_rsp.root != '0) ? ST_SO_GO : ST_TR_GO;
         end
         ST_SO_GO:     state_in = ST_SO_WAIT;
         ST_SO_WAIT:   if (div_rsp.done) state_in = ST_TR_GO;
         ST_TR_GO:     state_in = (init_ff != '0) ? ST_TR_WAIT : ST_OUT;
         ST_TR_WAIT:   if (div_rsp.done) state_in = ST_OUT;
         ST_OUT:       if (out_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= EB'(1);
         rfa_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INITIAL_EQUITY: init_ff <= csr_data[EB-1:0];
            CSR_RISK_FREE:      rfa_ff  <= csr_data[15:0];
            default:            init_ff <= init_ff;
         endcase
      end
   end

   // curve state
   always_ff @(posedge clock) begin
      if (reset || out_load) begin
         prev_ff  <= '0;
         sidx_ff  <= '0;
         rs_ff    <= '0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
         dsq_ff   <= '0;
         dcnt_ff  <= '0;
         dpk_ff   <= '0;
         opk_ff   <= reset ? EB'(1) : init_ff;
         worst_ff <= '0;
         pos_ff   <= '0;
         ws_ff    <= '0;
         we_ff    <= '0;
      end else begin
         if (in_take) begin
            if (sidx_ff == '0) begin
               dpk_ff <= req_equity;
               pos_ff <= '0;
            end else if (req_equity > dpk_ff) begin
               dpk_ff <= req_equity;
               pos_ff <= sidx_ff;
            end
            if (req_equity > opk_ff) opk_ff <= req_equity;
            if (sidx_ff != CNT_MAX) sidx_ff <= sidx_ff + 1'b1;
         end
         if (state_ff == ST_SQ_ACC) begin
            sum_ff   <= mag_neg_ff ? (sum_ff - SUM_W'(mag_ff)) : (sum_ff + SUM_W'(mag_ff));
            sqsum_ff <= sqsum_add[64] ? '1 : sqsum_add[63:0];
            // only strictly negative returns feed the downside sums
            if (mag_neg_ff && mag_ff != '0) begin
               dsq_ff  <= dsq_add[64] ? '1 : dsq_add[63:0];
               dcnt_ff <= dcnt_ff + 1'b1;
            end
            rs_ff <= rs_ff + 1'b1;
         end
         if (state_ff == ST_DD_GO) prev_ff <= e_ff;
         if (state_ff == ST_DD_WAIT && div_rsp.done && div_rsp.quo[32:0] > worst_ff) begin
            worst_ff <= div_rsp.quo[32:0];
            ws_ff    <= pos_ff;
            we_ff    <= idx_ff;
         end
      end
   end

   // per-word and final work registers
   always_ff @(posedge clock) begin
      if (in_take) begin
         e_ff    <= req_equity;
         last_ff <= req_last;
         idx_ff  <= sidx_ff;
      end
      if (state_ff == ST_RET_WAIT && div_rsp.done) begin
         mag_ff     <= div_rsp.quo[MEAN_W-1:0];
         mag_neg_ff <= ret_neg;
      end
      if (state_ff == ST_MEAN_GO) begin
         mean_ff     <= '0;
         mean_neg_ff <= 1'b0;
         sd_ff       <= '0;
         dsd_ff      <= '0;
         sh_neg_ff   <= 1'b0;
         sharpe_ff   <= '0;
         sortino_ff  <= '0;
         tr_ff       <= '0;
      end
      if (state_ff == ST_MEAN_WAIT && div_rsp.done) begin
         mean_ff     <= div_rsp.quo[MEAN_W-1:0];
         mean_neg_ff <= sum_neg && (div_rsp.quo != '0);
      end
      if (state_ff == ST_MSQ_LATCH) msq_ff <= prod_ff[63:SQUARE_DROP];
      if (state_ff == ST_NM_HI) plo_ff <= prod_ff;
      if (state_ff == ST_DEV) dev_ff <= (sqsum_ff > nm) ? (sqsum_ff - nm) : '0;
      if (state_ff == ST_SD_WAIT && sqrt_rsp.done) sd_ff <= sqrt_rsp.root;
      if (state_ff == ST_RF_WAIT && div_rsp.done) begin
         if (!mean_neg_ff && mean_ext >= rf_ext) begin
            num_ff    <= mean_ext - rf_ext;
            sh_neg_ff <= 1'b0;
         end else if (!mean_neg_ff) begin
            num_ff    <= rf_ext - mean_ext;
            sh_neg_ff <= 1'b1;
         end else begin
            num_ff    <= mean_ext + rf_ext;
            sh_neg_ff <= 1'b1;
         end
      end
      if (state_ff == ST_SH_WAIT && div_rsp.done) sharpe_ff <= div_rsp.quo[31:0];
      if (state_ff == ST_DSD_WAIT && sqrt_rsp.done) dsd_ff <= sqrt_rsp.root;
      if (state_ff == ST_SO_WAIT && div_rsp.done) sortino_ff <= div_rsp.quo[31:0];
      if (state_ff == ST_TR_WAIT && div_rsp.done) begin
         tr_ff <= tr_neg ? (~div_rsp.quo[31:0] + 1'b1) : div_rsp.quo[31:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (out_take) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_vol_ff     <= (|sd_ff[ROOT_W-1:32]) ? '1 : sd_ff[31:0];
         o_sharpe_ff  <= sh_neg_ff ? (~sharpe_ff + 1'b1) : sharpe_ff;
         o_sortino_ff <= mean_neg_ff ? (~sortino_ff + 1'b1) : sortino_ff;
         o_dd_ff      <= worst_ff;
         o_len_ff     <= we_ff - ws_ff;
         o_peak_ff    <= (opk_ff > init_ff) ? opk_ff : init_ff;
         o_tr_ff      <= tr_ff;
         o_cnt_ff     <= rs_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_volatility      = o_vol_ff;
   assign rsp_sharpe_tick     = o_sharpe_ff;
   assign rsp_sortino_tick    = o_sortino_ff;
   assign rsp_max_drawdown    = o_dd_ff;
   assign rsp_drawdown_length = o_len_ff;
   assign rsp_peak_equity     = o_peak_ff;
   assign rsp_total_return    = o_tr_ff;
   assign rsp_return_count    = o_cnt_ff;

   // a result word only appears from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result word raised outside the output state");

   // the shared divider is never restarted while it is still working
   assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // no division or root is in flight while a new word can be taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!div_rsp.busy && !sqrt_rsp.busy))
      else $error("arithmetic unit busy while idle");

   // the return count never passes the sample count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (rs_ff <= sidx_ff))
      else $error("return count exceeds sample count");

endmodule
